// ===== src/fsts_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and register indexes for the fixed-step tick scheduler.
package fsts_pkg;

   localparam int TICK_COUNT_WIDTH = 32;
   localparam int BURST_LIMIT      = 32;

   localparam int PERIOD_WIDTH = 32;
   localparam int SCALE_WIDTH  = 16;
   localparam int DELTA_WIDTH  = 32;
   localparam int LIMIT_WIDTH  = 6;
   localparam int ACC_WIDTH    = 48;
   localparam int SCALE_FRAC   = 8;
   localparam int SCALED_WIDTH = DELTA_WIDTH + SCALE_WIDTH - SCALE_FRAC;
   localparam int PROD_WIDTH   = PERIOD_WIDTH + LIMIT_WIDTH;
   localparam int NUM_WIDTH    = 32;
   localparam int ALPHA_WIDTH  = 16;
   localparam int ALPHA_BITS   = 15;
   localparam int STEP_WIDTH   = $clog2(ALPHA_BITS);
   localparam int CSR_IDX_WIDTH = 2;
   localparam int CSR_WIDTH     = 32;

   localparam logic [ALPHA_WIDTH-1:0] ALPHA_ONE = ALPHA_WIDTH'(1 << ALPHA_BITS);
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_MAX = LIMIT_WIDTH'(BURST_LIMIT);

   localparam int Q_DEPTH     = 2;
   localparam int Q_PTR_WIDTH = $clog2(Q_DEPTH);
   localparam int Q_CNT_WIDTH = $clog2(Q_DEPTH + 1);

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TICK_PERIOD = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TIME_SCALE  = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MAX_TICKS   = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ENABLED     = 2'd3;

   // input operation codes
   localparam logic OP_ADVANCE = 1'b0;
   localparam logic OP_CLEAR   = 1'b1;

   typedef enum logic [1:0] {
      CMD_ADVANCE,
      CMD_HOLD,
      CMD_CLEAR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type             kind;
      logic [SCALED_WIDTH-1:0]  scaled;
      logic [LIMIT_WIDTH-1:0]   limit;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_CLAMP,
      ST_DIV_INIT,
      ST_DIV_STEP,
      ST_SUMMARY
   } back_state_type;

endpackage

// ===== src/fsts_req_if.sv =====
`timescale 1ns / 1ps
// Input channel: advance and clear transactions.
interface fsts_req_if;
   import fsts_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   operation;
   logic [DELTA_WIDTH-1:0] delta_time;

   modport source (output valid, output operation, output delta_time, input ready);
   modport sink (input valid, input operation, input delta_time, output ready);
endinterface

// ===== src/fsts_rsp_if.sv =====
`timescale 1ns / 1ps
// Result channel: tick and summary transactions.
interface fsts_rsp_if;
   import fsts_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   is_tick;
   logic [NUM_WIDTH-1:0]   tick_number;
   logic [LIMIT_WIDTH-1:0] ticks_this_update;
   logic [ALPHA_WIDTH-1:0] interp_alpha;
   logic                   last;

   modport source (output valid, output is_tick, output tick_number,
                   output ticks_this_update, output interp_alpha, output last,
                   input ready);
   modport sink (input valid, input is_tick, input tick_number,
                 input ticks_this_update, input interp_alpha, input last,
                 output ready);
endinterface

// ===== src/fixed_step_tick_scheduler_core.sv =====
`timescale 1ns / 1ps
// Top level of the fixed-step tick scheduler: CSRs, front end, queue and back end.
//
// req_ch takes advance and clear transactions (valid/ready). Each one produces
// zero or more tick transactions on rsp_ch, followed by one summary with last
// set, carrying the tick count and the Q1.15 interpolation alpha.
// The front end scales the elapsed time and places a command in a two-entry
// queue; the back end works through one command at a time.
// Steps of an advance: load the accumulator, emit each tick (at most 32), leave
// the tick loop, apply the backlog clamp, set up the divider, run the restoring
// alpha division (one quotient bit per cycle) and emit the summary. The division
// is skipped when the period is zero or a whole period is left over. A clear goes
// straight to the summary; a disabled advance goes through the divider to it.
// Results leave through an output register; while a transaction waits the back
// end can still clamp and divide, but holds in the tick and summary states; when
// rsp_ch stalls the queue then fills and req_ch.ready drops.
// Reset (synchronous, active high) empties the queue, clears the accumulator
// and tick counter and loads the CSR defaults. Write CSRs only while idle.
module fixed_step_tick_scheduler_core import fsts_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]     csr_wdata,
   fsts_req_if.sink                 req_ch,
   fsts_rsp_if.source               rsp_ch
);

   logic [PERIOD_WIDTH-1:0] tick_period_ff;
   logic [SCALE_WIDTH-1:0]  time_scale_ff;
   logic [LIMIT_WIDTH-1:0]  max_ticks_ff;
   logic                    enabled_ff;

   logic    push;
   logic    pop;
   logic    q_full;
   logic    q_empty;
   cmd_type push_cmd;
   cmd_type head_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_period_ff <= PERIOD_WIDTH'(262144);
         time_scale_ff  <= SCALE_WIDTH'(256);
         max_ticks_ff   <= LIMIT_WIDTH'(10);
         enabled_ff     <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TICK_PERIOD: tick_period_ff <= csr_wdata[PERIOD_WIDTH-1:0];
            CSR_TIME_SCALE:  time_scale_ff  <= csr_wdata[SCALE_WIDTH-1:0];
            CSR_MAX_TICKS:   max_ticks_ff   <= csr_wdata[LIMIT_WIDTH-1:0];
            CSR_ENABLED:     enabled_ff     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   fsts_front u_front (
      .req_ch     (req_ch),
      .time_scale (time_scale_ff),
      .max_ticks  (max_ticks_ff),
      .enabled    (enabled_ff),
      .q_full     (q_full),
      .push       (push),
      .cmd        (push_cmd)
   );

   fsts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .pop       (pop),
      .head      (head_cmd),
      .full      (q_full),
      .empty     (q_empty)
   );

   fsts_back u_back (
      .clock       (clock),
      .reset       (reset),
      .tick_period (tick_period_ff),
      .head        (head_cmd),
      .empty       (q_empty),
      .pop         (pop),
      .rsp_ch      (rsp_ch)
   );

endmodule

// ===== src/fsts_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts requests, classifies them and scales the elapsed time.
module fsts_front import fsts_pkg::*; (
   fsts_req_if.sink                req_ch,
   input  logic [SCALE_WIDTH-1:0]  time_scale,
   input  logic [LIMIT_WIDTH-1:0]  max_ticks,
   input  logic                    enabled,
   input  logic                    q_full,
   output logic                    push,
   output cmd_type                 cmd
);

   logic [DELTA_WIDTH+SCALE_WIDTH-1:0] product;

   assign req_ch.ready = !q_full;
   assign push         = req_ch.valid && !q_full;
   assign product      = (DELTA_WIDTH+SCALE_WIDTH)'(req_ch.delta_time) *
                         (DELTA_WIDTH+SCALE_WIDTH)'(time_scale);

   always_comb begin
      cmd.scaled = product[DELTA_WIDTH+SCALE_WIDTH-1:SCALE_FRAC];
      // zero limit behaves as one, oversize limits are capped
      if (max_ticks == '0) begin
         cmd.limit = LIMIT_WIDTH'(1);
      end else if (max_ticks > LIMIT_MAX) begin
         cmd.limit = LIMIT_MAX;
      end else begin
         cmd.limit = max_ticks;
      end
      if (req_ch.operation == OP_CLEAR) begin
         cmd.kind = CMD_CLEAR;
      end else if (!enabled) begin
         cmd.kind = CMD_HOLD;
      end else begin
         cmd.kind = CMD_ADVANCE;
      end
   end

endmodule

// ===== src/fsts_queue.sv =====
`timescale 1ns / 1ps
// Short command queue between the front and back ends.
module fsts_queue import fsts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output cmd_type head,
   output logic    full,
   output logic    empty
);

   cmd_type                 mem [Q_DEPTH];
   logic [Q_PTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_WIDTH-1:0]  count_ff, count_in;

   assign full  = (count_ff == Q_CNT_WIDTH'(Q_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_WIDTH'(Q_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_WIDTH'(Q_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/fsts_back.sv =====
`timescale 1ns / 1ps
// Back end: accumulator, tick loop, backlog clamp, alpha divider and output register.
module fsts_back import fsts_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [PERIOD_WIDTH-1:0] tick_period,
   input  cmd_type                 head,
   input  logic                    empty,
   output logic                    pop,
   fsts_rsp_if.source              rsp_ch
);

   back_state_type                state_ff, state_in;
   logic [ACC_WIDTH-1:0]          acc_ff, acc_in;
   logic [TICK_COUNT_WIDTH-1:0]   counter_ff, counter_in;
   logic [LIMIT_WIDTH-1:0]        cnt_ff, cnt_in;
   logic [LIMIT_WIDTH-1:0]        limit_ff, limit_in;
   logic [PROD_WIDTH-1:0]         prod_ff, prod_in;
   logic [PERIOD_WIDTH-1:0]       rem_ff, rem_in;
   logic [ALPHA_BITS-1:0]         quo_ff, quo_in;
   logic [STEP_WIDTH-1:0]         step_ff, step_in;
   logic [ALPHA_WIDTH-1:0]        alpha_ff, alpha_in;

   logic                          rsp_valid_ff;
   logic                          rsp_is_tick_ff;
   logic [NUM_WIDTH-1:0]          rsp_num_ff;
   logic [LIMIT_WIDTH-1:0]        rsp_cnt_ff;
   logic [ALPHA_WIDTH-1:0]        rsp_alpha_ff;

   logic                          out_free;
   logic                          load;
   logic                          load_tick;
   logic [ACC_WIDTH:0]            sum;
   logic [ACC_WIDTH-1:0]          period_ext;
   logic [PERIOD_WIDTH:0]         shifted;
   logic                          qbit;

   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign period_ext = ACC_WIDTH'(tick_period);
   assign sum        = (ACC_WIDTH+1)'(acc_ff) + (ACC_WIDTH+1)'(head.scaled);
   assign shifted    = {rem_ff, 1'b0};

   always_comb begin
      state_in   = state_ff;
      acc_in     = acc_ff;
      counter_in = counter_ff;
      cnt_in     = cnt_ff;
      limit_in   = limit_ff;
      prod_in    = prod_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      step_in    = step_ff;
      alpha_in   = alpha_ff;
      pop        = 1'b0;
      load       = 1'b0;
      load_tick  = 1'b0;
      qbit       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               pop    = 1'b1;
               cnt_in = '0;
               case (head.kind)
                  CMD_CLEAR: begin
                     acc_in     = '0;
                     counter_in = '0;
                     alpha_in   = '0;
                     state_in   = ST_SUMMARY;
                  end
                  CMD_HOLD: begin
                     state_in = ST_DIV_INIT;
                  end
                  CMD_ADVANCE: begin
                     // saturating add
                     acc_in   = sum[ACC_WIDTH] ? '1 : sum[ACC_WIDTH-1:0];
                     limit_in = head.limit;
                     prod_in  = PROD_WIDTH'(tick_period) * PROD_WIDTH'(head.limit);
                     state_in = ST_TICK;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_TICK: begin
            if (acc_ff >= period_ext && cnt_ff < limit_ff) begin
               if (out_free) begin
                  load       = 1'b1;
                  load_tick  = 1'b1;
                  acc_in     = acc_ff - period_ext;
                  counter_in = counter_ff + 1'b1;
                  cnt_in     = cnt_ff + 1'b1;
               end
            end else begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            if (acc_ff >= ACC_WIDTH'(prod_ff)) begin
               acc_in = ACC_WIDTH'(prod_ff) - period_ext;
            end
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            if (tick_period == '0) begin
               alpha_in = '0;
               state_in = ST_SUMMARY;
            end else if (acc_ff >= period_ext) begin
               alpha_in = ALPHA_ONE;
               state_in = ST_SUMMARY;
            end else begin
               rem_in   = acc_ff[PERIOD_WIDTH-1:0];
               quo_in   = '0;
               step_in  = '0;
               state_in = ST_DIV_STEP;
            end
         end
         ST_DIV_STEP: begin
            // one restoring quotient bit per cycle
            if (shifted >= {1'b0, tick_period}) begin
               qbit   = 1'b1;
               rem_in = PERIOD_WIDTH'(shifted - {1'b0, tick_period});
            end else begin
               rem_in = shifted[PERIOD_WIDTH-1:0];
            end
            quo_in = {quo_ff[ALPHA_BITS-2:0], qbit};
            if (step_ff == STEP_WIDTH'(ALPHA_BITS-1)) begin
               alpha_in = ALPHA_WIDTH'(quo_in);
               state_in = ST_SUMMARY;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_SUMMARY: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         acc_ff     <= '0;
         counter_ff <= '0;
      end else begin
         state_ff   <= state_in;
         acc_ff     <= acc_in;
         counter_ff <= counter_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      limit_ff <= limit_in;
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      step_ff  <= step_in;
      alpha_ff <= alpha_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_is_tick_ff <= load_tick;
         rsp_num_ff     <= NUM_WIDTH'(counter_ff);
         rsp_cnt_ff     <= load_tick ? '0 : cnt_ff;
         rsp_alpha_ff   <= load_tick ? '0 : alpha_ff;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.is_tick           = rsp_is_tick_ff;
   assign rsp_ch.tick_number       = rsp_num_ff;
   assign rsp_ch.ticks_this_update = rsp_cnt_ff;
   assign rsp_ch.interp_alpha      = rsp_alpha_ff;
   assign rsp_ch.last              = !rsp_is_tick_ff;

   a_burst_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TICK) |-> (cnt_ff <= limit_ff))
      else $error("tick burst exceeded its limit");

   a_clamp_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLAMP && tick_period != '0) |=> (acc_ff < ACC_WIDTH'(prod_ff)))
      else $error("backlog not clamped below period times limit");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_STEP) |-> (rem_ff < tick_period))
      else $error("divider remainder out of range");

endmodule

// ===== dv/fsts_tick_checker.sv =====
`timescale 1ns / 1ps
// Checker for the tick scheduler: tracks the CSRs, predicts tick and summary transactions, compares.
module fsts_tick_checker import fsts_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]     csr_wdata,
   fsts_req_if                      req_mon,
   fsts_rsp_if                      rsp_mon,
   output int                       fail_count,
   output int                       outstanding
);

   localparam logic [PERIOD_WIDTH-1:0] PERIOD_DEFAULT = 32'd262144;
   localparam logic [SCALE_WIDTH-1:0]  SCALE_DEFAULT  = 16'd256;
   localparam logic [LIMIT_WIDTH-1:0]  TICKS_DEFAULT  = 6'd10;
   localparam logic [63:0]             ACC_CEILING    = (64'd1 << ACC_WIDTH) - 64'd1;

   typedef struct {
      logic                   is_tick;
      logic [NUM_WIDTH-1:0]   tick_number;
      logic [LIMIT_WIDTH-1:0] ticks_this_update;
      logic [ALPHA_WIDTH-1:0] interp_alpha;
      logic                   last;
   } tick_result_type;

   tick_result_type due_results[$];

   logic [PERIOD_WIDTH-1:0]     cfg_period;
   logic [SCALE_WIDTH-1:0]      cfg_scale;
   logic [LIMIT_WIDTH-1:0]      cfg_max_ticks;
   logic                        cfg_enabled;
   logic [ACC_WIDTH-1:0]        time_acc;
   logic [TICK_COUNT_WIDTH-1:0] tick_count;

   function automatic logic [ALPHA_WIDTH-1:0] leftover_alpha(logic [ACC_WIDTH-1:0] acc);
      logic [63:0] quotient;
      if (cfg_period == '0)
         return '0;
      quotient = (64'(acc) << ALPHA_BITS) / 64'(cfg_period);
      return (quotient > 64'(ALPHA_ONE)) ? ALPHA_ONE : quotient[ALPHA_WIDTH-1:0];
   endfunction

   function automatic void expect_result(logic is_tick, logic [TICK_COUNT_WIDTH-1:0] number,
                                         logic [LIMIT_WIDTH-1:0] count,
                                         logic [ALPHA_WIDTH-1:0] alpha, logic fin);
      tick_result_type item;
      item.is_tick           = is_tick;
      item.tick_number       = NUM_WIDTH'(number);
      item.ticks_this_update = count;
      item.interp_alpha      = alpha;
      item.last              = fin;
      due_results.push_back(item);
   endfunction

   function automatic void advance_scheduler(logic op, logic [DELTA_WIDTH-1:0] delta);
      logic [63:0]            burst;
      logic [63:0]            total;
      logic [63:0]            backlog_cap;
      logic [LIMIT_WIDTH-1:0] emitted;
      emitted = '0;
      if (op == OP_CLEAR) begin
         time_acc   = '0;
         tick_count = '0;
         expect_result(1'b0, '0, '0, '0, 1'b1);
         return;
      end
      if (!cfg_enabled) begin
         expect_result(1'b0, tick_count, '0, leftover_alpha(time_acc), 1'b1);
         return;
      end
      if (cfg_max_ticks == '0)
         burst = 64'd1;
      else if (cfg_max_ticks > LIMIT_MAX)
         burst = 64'(BURST_LIMIT);
      else
         burst = 64'(cfg_max_ticks);
      total    = 64'(time_acc) + ((64'(delta) * 64'(cfg_scale)) >> SCALE_FRAC);
      time_acc = (total > ACC_CEILING) ? ACC_CEILING[ACC_WIDTH-1:0] : total[ACC_WIDTH-1:0];
      while (time_acc >= cfg_period && 64'(emitted) < burst) begin
         expect_result(1'b1, tick_count, '0, '0, 1'b0);
         time_acc   = time_acc - cfg_period;
         tick_count = tick_count + 1'b1;
         emitted    = emitted + 1'b1;
      end
      // backlog clamp: never carry a full burst into the next frame
      backlog_cap = 64'(cfg_period) * burst;
      if (64'(time_acc) >= backlog_cap)
         time_acc = ACC_WIDTH'(backlog_cap - 64'(cfg_period));
      expect_result(1'b0, tick_count, emitted, leftover_alpha(time_acc), 1'b1);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin : monitor
      tick_result_type want;
      if (reset) begin
         cfg_period    = PERIOD_DEFAULT;
         cfg_scale     = SCALE_DEFAULT;
         cfg_max_ticks = TICKS_DEFAULT;
         cfg_enabled   = 1'b0;
         time_acc      = '0;
         tick_count    = '0;
         due_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TICK_PERIOD: cfg_period    = csr_wdata[PERIOD_WIDTH-1:0];
               CSR_TIME_SCALE:  cfg_scale     = csr_wdata[SCALE_WIDTH-1:0];
               CSR_MAX_TICKS:   cfg_max_ticks = csr_wdata[LIMIT_WIDTH-1:0];
               CSR_ENABLED:     cfg_enabled   = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            advance_scheduler(req_mon.operation, req_mon.delta_time);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_results.size() == 0) begin
               report_mismatch("transaction with nothing expected",
                               64'({rsp_mon.is_tick, rsp_mon.tick_number,
                                    rsp_mon.ticks_this_update, rsp_mon.interp_alpha,
                                    rsp_mon.last}), '0);
            end else begin
               want = due_results.pop_front();
               if (rsp_mon.is_tick !== want.is_tick)
                  report_mismatch("is_tick", 64'(rsp_mon.is_tick), 64'(want.is_tick));
               if (rsp_mon.tick_number !== want.tick_number)
                  report_mismatch("tick_number", 64'(rsp_mon.tick_number),
                                  64'(want.tick_number));
               if (rsp_mon.ticks_this_update !== want.ticks_this_update)
                  report_mismatch("ticks_this_update", 64'(rsp_mon.ticks_this_update),
                                  64'(want.ticks_this_update));
               if (rsp_mon.interp_alpha !== want.interp_alpha)
                  report_mismatch("interp_alpha", 64'(rsp_mon.interp_alpha),
                                  64'(want.interp_alpha));
               if (rsp_mon.last !== want.last)
                  report_mismatch("last", 64'(rsp_mon.last), 64'(want.last));
            end
         end
      end
      outstanding = due_results.size();
   end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the tick scheduler: clock, reset, CSR set-up, traffic and verdict.
module tb_top;
   import fsts_pkg::*;

   localparam int HOLD_CYCLES   = 400;
   localparam int QUIET_LIMIT   = 3000;
   localparam int SETTLE_CYCLES = 60;
   localparam int RANDOM_PHASES = 9;
   localparam int PHASE_ITEMS   = 24;

   logic                     clock;
   logic                     reset;
   logic                     csr_we;
   logic [CSR_IDX_WIDTH-1:0] csr_index;
   logic [CSR_WIDTH-1:0]     csr_wdata;
   int                       fail_count;
   int                       outstanding;
   bit                       hold_rsp;
   bit                       no_idle;
   logic [PERIOD_WIDTH-1:0]  cur_period;
   logic [SCALE_WIDTH-1:0]   cur_scale;

   fsts_req_if req_ch();
   fsts_rsp_if rsp_ch();

   fixed_step_tick_scheduler_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   fsts_tick_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // offer one transaction after a random gap; returns at the edge that accepts it
   task automatic send_transaction(input logic op, input logic [DELTA_WIDTH-1:0] delta);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.operation  <= op;
      req_ch.delta_time <= delta;
      @(negedge clock);
      while (!req_ch.ready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // write enable stays high across the four writes
   task automatic set_config(input logic [PERIOD_WIDTH-1:0] period,
                             input logic [SCALE_WIDTH-1:0] scale,
                             input logic [LIMIT_WIDTH-1:0] max_ticks, input logic enable);
      cur_period = period;
      cur_scale  = scale;
      csr_we    <= 1'b1;
      csr_index <= CSR_TICK_PERIOD;
      csr_wdata <= period;
      @(posedge clock);
      csr_index <= CSR_TIME_SCALE;
      csr_wdata <= CSR_WIDTH'(scale);
      @(posedge clock);
      csr_index <= CSR_MAX_TICKS;
      csr_wdata <= CSR_WIDTH'(max_ticks);
      @(posedge clock);
      csr_index <= CSR_ENABLED;
      csr_wdata <= CSR_WIDTH'(enable);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // elapsed time aimed at a few periods of scaled time, with odd values mixed in
   function automatic logic [DELTA_WIDTH-1:0] pick_delta();
      int unsigned sel;
      logic [63:0] goal;
      logic [63:0] raw;
      sel = $urandom_range(0, 15);
      if (sel == 0)
         return '0;
      if (sel == 1)
         return '1;
      if (sel <= 4)
         return $urandom();
      // goal in tenths of a period; now and then a long frame hitch
      goal = 64'(cur_period) * ((sel == 5) ? $urandom_range(0, 400) : $urandom_range(0, 45))
             / 10;
      raw = (cur_scale == '0) ? goal
                              : ((goal << SCALE_FRAC) / cur_scale + $urandom_range(0, 1));
      return (raw > 64'(32'hFFFF_FFFF)) ? '1 : raw[DELTA_WIDTH-1:0];
   endfunction

   initial begin : receiver
      int unsigned stall;
      bit          hold_done;
      hold_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp && !hold_done) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         stall = no_idle ? 0 : $urandom_range(0, 7);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(negedge clock);
         while (!rsp_ch.valid) @(negedge clock);
         @(posedge clock);
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(negedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      int unsigned             pick;
      logic [PERIOD_WIDTH-1:0] period;
      logic [SCALE_WIDTH-1:0]  scale;
      logic [LIMIT_WIDTH-1:0]  burst;
      logic                    enable;
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= CSR_TICK_PERIOD;
      csr_wdata         <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.operation  <= OP_ADVANCE;
      req_ch.delta_time <= '0;
      cur_period = 32'd262144;
      cur_scale  = 16'd256;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // out of reset the block is disabled: summaries only, state untouched
      send_transaction(OP_ADVANCE, '0);
      send_transaction(OP_ADVANCE, '1);
      send_transaction(OP_CLEAR, '1);

      // real time: exact tick, leftover fraction, huge hitch with clamp
      wait_for_results();
      set_config(32'd262144, 16'd256, 6'd10, 1'b1);
      send_transaction(OP_ADVANCE, 32'd262144);
      send_transaction(OP_ADVANCE, 32'd100);
      send_transaction(OP_ADVANCE, '1);
      send_transaction(OP_ADVANCE, '0);

      // disabled with a backlog held: alpha of the kept accumulator, clear still works
      wait_for_results();
      set_config(32'd262144, 16'd256, 6'd10, 1'b0);
      send_transaction(OP_ADVANCE, 32'd12345);
      send_transaction(OP_CLEAR, '0);

      // widest period and scale, limit above the burst ceiling
      wait_for_results();
      set_config('1, '1, '1, 1'b1);
      send_transaction(OP_ADVANCE, '1);
      send_transaction(OP_ADVANCE, 32'd1);

      // zero period with zero limit: one tick per advance, alpha zero
      wait_for_results();
      set_config('0, 16'd1, '0, 1'b1);
      send_transaction(OP_ADVANCE, '0);
      send_transaction(OP_ADVANCE, 32'd5);

      // zero scale: no time passes whatever the delta
      wait_for_results();
      set_config(32'd1, '0, 6'd32, 1'b1);
      send_transaction(OP_ADVANCE, '1);
      send_transaction(OP_CLEAR, '0);
      send_transaction(OP_ADVANCE, 32'hA5A5_5A5A);

      // limit of one: the clamp drops the whole remainder
      wait_for_results();
      set_config(32'd7, 16'd256, 6'd1, 1'b1);
      send_transaction(OP_ADVANCE, 32'd100);
      send_transaction(OP_ADVANCE, 32'd3);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_results();
         pick = $urandom_range(0, 9);
         if (pick == 0)
            period = '0;
         else if (pick == 1)
            period = '1;
         else if (pick <= 3)
            period = $urandom();
         else
            period = $urandom_range(1, 32'h0010_0000);
         pick = $urandom_range(0, 7);
         if (pick == 0)
            scale = '0;
         else if (pick == 1)
            scale = '1;
         else if (pick <= 3)
            scale = 16'd256;
         else
            scale = SCALE_WIDTH'($urandom_range(1, 16'hFFFF));
         pick = $urandom_range(0, 9);
         if (pick == 0)
            burst = '0;
         else if (pick == 1)
            burst = '1;
         else if (pick == 2)
            burst = LIMIT_MAX;
         else if (pick == 3)
            burst = 6'd1;
         else
            burst = LIMIT_WIDTH'($urandom_range(1, 12));
         enable = (phase == 1) || ($urandom_range(0, 5) != 0);
         set_config(period, scale, burst, enable);
         // phase 1: receiver stalls long so the queue fills; phase 3: back to back
         hold_rsp = (phase == 1);
         no_idle  = (phase == 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 11) == 0)
               send_transaction(OP_CLEAR, $urandom());
            else
               send_transaction(OP_ADVANCE, pick_delta());
         end
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
